// ===== rtl/iprt_pkg.sv =====
// ----------------------------------------------------------------------------
// iprt_pkg
// Shared types, constants and digit tables for the base 2^r text converter.
// ----------------------------------------------------------------------------
package iprt_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int RADIX_W     = 3;
  localparam int RADIX_MAX   = 5;
  localparam int SYMBOL_W    = 7;

  // digit shifter: wide enough for the longest digit-aligned magnitude
  localparam int SHIFT_W = VALUE_WIDTH + RADIX_MAX - 1;
  localparam int CNT_W   = $clog2(SHIFT_W + 1);

  localparam int NDIG_R1 = VALUE_WIDTH;
  localparam int NDIG_R2 = (VALUE_WIDTH + 1) / 2;
  localparam int NDIG_R3 = (VALUE_WIDTH + 2) / 3;
  localparam int NDIG_R4 = (VALUE_WIDTH + 3) / 4;
  localparam int NDIG_R5 = (VALUE_WIDTH + 4) / 5;

  localparam int PAD_R1 = SHIFT_W - NDIG_R1;
  localparam int PAD_R2 = SHIFT_W - NDIG_R2 * 2;
  localparam int PAD_R3 = SHIFT_W - NDIG_R3 * 3;
  localparam int PAD_R4 = SHIFT_W - NDIG_R4 * 4;
  localparam int PAD_R5 = SHIFT_W - NDIG_R5 * 5;

  localparam logic [RADIX_W-1:0]  RADIX_RESET = 3'd4;
  localparam logic [SYMBOL_W-1:0] MINUS_CHAR  = 7'h2D;
  localparam logic [SYMBOL_W-1:0] ZERO_CHAR   = 7'h30;
  localparam logic [SYMBOL_W-1:0] ALPHA_CHAR  = 7'h41;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DIGITS
  } iprt_state_t;

  typedef struct packed {
    logic load;
    logic emit_sign;
    logic emit_digit;
    logic last;
  } iprt_cmd_t;

  typedef struct packed {
    logic             out_free;
    logic             neg;
    logic [CNT_W-1:0] ndig;
  } iprt_stat_t;

  // clamp the register to the legal range 1..5
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r == '0) begin
      res = RADIX_W'(1);
    end else if (r > RADIX_W'(RADIX_MAX)) begin
      res = RADIX_W'(RADIX_MAX);
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [CNT_W-1:0] num_digits(input logic [RADIX_W-1:0] r);
    logic [CNT_W-1:0] res;
    unique case (r)
      3'd1:    res = CNT_W'(NDIG_R1);
      3'd2:    res = CNT_W'(NDIG_R2);
      3'd3:    res = CNT_W'(NDIG_R3);
      3'd4:    res = CNT_W'(NDIG_R4);
      default: res = CNT_W'(NDIG_R5);
    endcase
    return res;
  endfunction

  function automatic logic [CNT_W-1:0] lead_pad(input logic [RADIX_W-1:0] r);
    logic [CNT_W-1:0] res;
    unique case (r)
      3'd1:    res = CNT_W'(PAD_R1);
      3'd2:    res = CNT_W'(PAD_R2);
      3'd3:    res = CNT_W'(PAD_R3);
      3'd4:    res = CNT_W'(PAD_R4);
      default: res = CNT_W'(PAD_R5);
    endcase
    return res;
  endfunction

  function automatic logic [SYMBOL_W-1:0] digit_char(input logic [RADIX_MAX-1:0] d);
    logic [SYMBOL_W-1:0] res;
    if (d < 5'd10) begin
      res = ZERO_CHAR + SYMBOL_W'(d);
    end else begin
      res = ALPHA_CHAR + SYMBOL_W'(d - 5'd10);
    end
    return res;
  endfunction

endpackage

// ===== rtl/iprt_if.sv =====
// ----------------------------------------------------------------------------
// iprt_if
// Valid/ready channels: input value, output symbol and radix configuration.
// ----------------------------------------------------------------------------
interface iprt_in_if
  import iprt_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface iprt_out_if
  import iprt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SYMBOL_W-1:0] symbol;
  logic                last_symbol;

  modport source (output valid, output symbol, output last_symbol, input ready);
  modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

interface iprt_cfg_if
  import iprt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [RADIX_W-1:0] radix_bits;

  modport source (output valid, output radix_bits, input ready);
  modport sink   (input valid, input radix_bits, output ready);
endinterface

// ===== rtl/int_to_pow2_radix_text_core.sv =====
// ----------------------------------------------------------------------------
// int_to_pow2_radix_text_core
// Converts signed 32-bit integers to ASCII text in base 2^r.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus  : one signed value per request (valid/ready).
//   out_bus : one ASCII character per request, most significant digit first;
//             a negative value starts with '-'; last_symbol marks the end.
//   cfg_bus : writes radix_bits (r, 1..5; 0 acts as 1, 6 and 7 act as 5).
//             Always ready; write it only while no conversion is running.
// Sequence: after an accepted request the sequencer steps through the sign
//   (negative values only) and then every digit position, ceil(32/r)
//   positions, leading zero positions included.
// Reset (rst_n low, synchronous): sequencer idle, output empty, r = 4.
// Stall: a character waits in the output register until taken; the
//   sequencer holds meanwhile. in_bus is ready whenever the sequencer is
//   idle, even while the final character still waits.
// ----------------------------------------------------------------------------
module int_to_pow2_radix_text_core
  import iprt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  iprt_in_if.sink    in_bus,
  iprt_out_if.source out_bus,
  iprt_cfg_if.sink   cfg_bus
);

  iprt_cmd_t  cmd;
  iprt_stat_t stat;

  assign cfg_bus.ready = 1'b1;

  iprt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  iprt_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_value        (in_bus.value),
    .cfg_valid       (cfg_bus.valid),
    .cfg_radix_bits  (cfg_bus.radix_bits),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_bus.valid),
    .out_ready       (out_bus.ready),
    .out_symbol      (out_bus.symbol),
    .out_last_symbol (out_bus.last_symbol)
  );

endmodule

// ===== rtl/iprt_ctrl.sv =====
// ----------------------------------------------------------------------------
// iprt_ctrl
// Sequencer: accepts a request, then steps sign and digit positions.
// ----------------------------------------------------------------------------
module iprt_ctrl
  import iprt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  iprt_stat_t stat,
  output iprt_cmd_t  cmd
);

  iprt_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.neg ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        if (stat.out_free) begin
          state_nxt = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (stat.out_free && cnt_r == CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SIGN: begin
        cmd.emit_sign = stat.out_free;
      end
      ST_DIGITS: begin
        cmd.emit_digit = stat.out_free;
        cmd.last       = (cnt_r == CNT_W'(1));
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      cnt_nxt = stat.ndig;
    end else if (cmd.emit_digit) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/iprt_datapath.sv =====
// ----------------------------------------------------------------------------
// iprt_datapath
// Radix register, magnitude shifter, digit lookup and output register.
// ----------------------------------------------------------------------------
module iprt_datapath
  import iprt_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic                          cfg_valid,
  input  logic [RADIX_W-1:0]            cfg_radix_bits,
  input  iprt_cmd_t                     cmd,
  output iprt_stat_t                    stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [SYMBOL_W-1:0]           out_symbol,
  output logic                          out_last_symbol
);

  logic [RADIX_W-1:0]     radix_r, radix_nxt;
  logic [SHIFT_W-1:0]     shift_r, shift_nxt;
  logic                   started_r, started_nxt;
  logic                   valid_r, valid_nxt;
  logic [SYMBOL_W-1:0]    symbol_r, symbol_nxt;
  logic                   last_r, last_nxt;

  logic [RADIX_W-1:0]     r_eff;
  logic [VALUE_WIDTH-1:0] mag;
  logic [RADIX_MAX-1:0]   digit;
  logic                   show_digit;

  assign r_eff = eff_radix(radix_r);
  // most negative value wraps to 2^(W-1), which is its unsigned magnitude
  assign mag   = in_value[VALUE_WIDTH-1] ? VALUE_WIDTH'(-in_value) : VALUE_WIDTH'(in_value);

  // top digit window, right-aligned to the active digit width
  assign digit      = shift_r[SHIFT_W-1 -: RADIX_MAX] >> (RADIX_W'(RADIX_MAX) - r_eff);
  // drop leading zero digits, but always show the final one
  assign show_digit = (digit != '0) || started_r || cmd.last;

  assign stat.out_free = !valid_r || out_ready;
  assign stat.neg      = in_value[VALUE_WIDTH-1];
  assign stat.ndig     = num_digits(r_eff);

  always_comb begin
    radix_nxt = cfg_valid ? cfg_radix_bits : radix_r;
  end

  always_comb begin
    shift_nxt   = shift_r;
    started_nxt = started_r;
    if (cmd.load) begin
      shift_nxt   = SHIFT_W'(mag) << lead_pad(r_eff);
      started_nxt = 1'b0;
    end else if (cmd.emit_digit) begin
      shift_nxt   = shift_r << r_eff;
      started_nxt = started_r || (digit != '0);
    end
  end

  always_comb begin
    symbol_nxt = symbol_r;
    last_nxt   = last_r;
    valid_nxt  = valid_r && !out_ready;
    if (cmd.emit_sign) begin
      symbol_nxt = MINUS_CHAR;
      last_nxt   = 1'b0;
      valid_nxt  = 1'b1;
    end else if (cmd.emit_digit && show_digit) begin
      symbol_nxt = digit_char(digit);
      last_nxt   = cmd.last;
      valid_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r   <= RADIX_RESET;
      started_r <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      radix_r   <= radix_nxt;
      started_r <= started_nxt;
      valid_r   <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r  <= shift_nxt;
    symbol_r <= symbol_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid       = valid_r;
  assign out_symbol      = symbol_r;
  assign out_last_symbol = last_r;

endmodule

// ===== rtl/iprt_checker.sv =====
// ----------------------------------------------------------------------------
// iprt_checker
// Port-level checks for the base 2^r text converter, bound to the top level.
// ----------------------------------------------------------------------------
module iprt_checker
  import iprt_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SYMBOL_W-1:0] symbol,
  input logic                last_symbol
);

  // hold a stalled character
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(symbol) && $stable(last_symbol))
    else $error("stalled output character changed");

  // one request at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a conversion runs");

  a_symbol_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (symbol == MINUS_CHAR) ||
                  (symbol >= 7'h30 && symbol <= 7'h39) ||
                  (symbol >= 7'h41 && symbol <= 7'h56))
    else $error("output character outside the digit set");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && symbol == MINUS_CHAR |-> !last_symbol)
    else $error("sign marked as final character");

endmodule

bind int_to_pow2_radix_text_core iprt_checker u_iprt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_bus.valid),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .symbol      (out_bus.symbol),
  .last_symbol (out_bus.last_symbol)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the base 2^r integer-to-text converter. Values are
// sent through the input channel in phases, one radix setting per phase. Each
// accepted value is expanded into its expected characters. Every character
// taken from the output channel is compared with the oldest one still waiting.
// ----------------------------------------------------------------------------
module tb_top;
  import iprt_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PCT     = 23;
  localparam int RANDOM_ITEMS = 50;
  localparam int STEADY_PHASE = 4;

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
  } text_char_t;

  logic clk;
  logic rst_n;

  iprt_in_if  in_if ();
  iprt_out_if out_if ();
  iprt_cfg_if cfg_if ();

  int_to_pow2_radix_text_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  logic signed [VALUE_WIDTH-1:0] pending_values[$];
  text_char_t                    expected_chars[$];
  text_char_t                    oldest_char;
  logic [RADIX_W-1:0]            model_radix;
  string                         digit_text = "0123456789ABCDEFGHIJKLMNOPQRSTUV";
  logic                          steady;
  int                            mismatches;
  int                            cycle_count;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // expand one value into its characters, sign first, top digit first
  function automatic void predict_text(input logic signed [VALUE_WIDTH-1:0] v,
                                       input logic [RADIX_W-1:0] rbits);
    int unsigned            r;
    int unsigned            ndig;
    int unsigned            i;
    logic [VALUE_WIDTH-1:0] mag;
    logic [VALUE_WIDTH-1:0] rest;
    logic [VALUE_WIDTH-1:0] d;
    text_char_t             c;
    r = rbits;
    if (r < 1) r = 1;
    if (r > RADIX_MAX) r = RADIX_MAX;
    mag = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
    ndig = 0;
    rest = mag;
    do begin
      ndig++;
      rest = rest >> r;
    end while (rest != '0);
    if (v[VALUE_WIDTH-1]) begin
      c.symbol = MINUS_CHAR;
      c.last   = 1'b0;
      expected_chars.push_back(c);
    end
    for (i = ndig; i > 0; i--) begin
      d = (mag >> ((i - 1) * r)) & ((1 << r) - 1);
      c.symbol = SYMBOL_W'(digit_text[d]);
      c.last   = (i == 1);
      expected_chars.push_back(c);
    end
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] random_value();
    logic signed [VALUE_WIDTH-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(0, VALUE_WIDTH - 1);
      2: v = $urandom_range(0, 40);
      default: begin
        case ($urandom_range(0, 3))
          0: v = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
          1: v = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
          2: v = '0;
          default: v = '1;
        endcase
      end
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // driver: present the head of the pending queue, drop it once taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_text(in_if.value, model_radix);
        void'(pending_values.pop_front());
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_values.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_if.valid <= 1'b1;
          in_if.value <= pending_values[0];
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each taken character against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected symbol %h last %b",
                                    out_if.symbol, out_if.last_symbol));
        end else begin
          oldest_char = expected_chars.pop_front();
          if (out_if.symbol !== oldest_char.symbol)
            report_mismatch($sformatf("symbol %h, want %h",
                                      out_if.symbol, oldest_char.symbol));
          if (out_if.last_symbol !== oldest_char.last)
            report_mismatch($sformatf("last_symbol %b, want %b on symbol %h",
                                      out_if.last_symbol, oldest_char.last,
                                      oldest_char.symbol));
        end
      end
      out_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_radix(input logic [RADIX_W-1:0] val);
    @(posedge clk);
    cfg_if.valid      <= 1'b1;
    cfg_if.radix_bits <= val;
    do @(posedge clk); while (!cfg_if.ready);
    model_radix = val;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_values.size() != 0 || in_if.valid || expected_chars.size() != 0);
  endtask

  logic [RADIX_W-1:0] phase_radix[9] = '{3'd4, 3'd1, 3'd5, 3'd0, 3'd7, 3'd2, 3'd6, 3'd3, 3'd4};

  initial begin
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.value       = '0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.radix_bits = '0;
    steady            = 1'b0;
    mismatches        = 0;
    cycle_count       = 0;
    model_radix       = RADIX_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 9; p++) begin
      // hold the sender until every character of the last phase is out
      wait_idle();
      if (p > 0) write_radix(phase_radix[p]);
      steady <= (p == STEADY_PHASE);
      @(negedge clk);
      pending_values.push_back('0);
      pending_values.push_back({1'b1, {(VALUE_WIDTH-1){1'b0}}});
      if (p == 0) begin
        pending_values.push_back(1);
        pending_values.push_back(-1);
        pending_values.push_back({1'b0, {(VALUE_WIDTH-1){1'b1}}});
        pending_values.push_back(15);
        pending_values.push_back(-16);
        pending_values.push_back(32'hAAAA_AAAA);
        pending_values.push_back(32'h5555_5555);
      end
      for (int k = 0; k < RANDOM_ITEMS; k++)
        pending_values.push_back(random_value());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/iprt_pkg.sv
rtl/iprt_if.sv
rtl/iprt_ctrl.sv
rtl/iprt_datapath.sv
rtl/int_to_pow2_radix_text_core.sv
rtl/iprt_checker.sv
bench/tb_top.sv
